[src/pack_object_header_parser_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the pack object header parser
// Clocked implication checks with the reset disable built in.
// ----------------------------------------------------------------------------
`ifndef PACK_OBJECT_HEADER_PARSER_UNIT_DEFINES_SVH
`define PACK_OBJECT_HEADER_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication under an active-low reset
`define POHP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under an active-low reset
`define POHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/pohp_pkg.sv]
// ----------------------------------------------------------------------------
// pohp_pkg
// Shared types and constants of the pack object header parser.
// ----------------------------------------------------------------------------
package pohp_pkg;

	// Object header layout
	localparam int BASE_ID_BYTES    = 20;
	localparam int MAX_OFFSET_BYTES = 8;
	localparam int HEADER_BYTES     = 12;
	localparam int MAGIC_BYTES      = 4;
	localparam int SIZE_SHIFT_INIT  = 4;
	localparam int SIZE_SHIFT_STEP  = 7;
	localparam int SIZE_SHIFT_MAX   = 28;

	localparam int OFS_W  = $clog2(MAX_OFFSET_BYTES + 1);
	localparam int BASE_W = $clog2(BASE_ID_BYTES);

	localparam logic [31:0] EXPECTED_LENGTH_RST = 32'd340027;

	localparam logic [7:0] MAGIC [MAGIC_BYTES] = '{8'h50, 8'h41, 8'h43, 8'h4b};

	localparam logic [2:0] OBJ_OFS_DELTA = 3'd6;
	localparam logic [2:0] OBJ_REF_DELTA = 3'd7;

	// Queue depths
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_PASS     = 3'd0,
		ST_BAD_HEX  = 3'd1,
		ST_SIZE_OVF = 3'd2,
		ST_OFS_OVF  = 3'd3,
		ST_HDR_FAIL = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		TK_BYTE   = 2'd0,
		TK_EOS    = 2'd1,
		TK_BADHEX = 2'd2
	} tok_kind_t;

	// Classified item from front to back
	typedef struct packed {
		tok_kind_t   kind;
		logic [7:0]  data;
		logic        pending;
	} token_t;

	typedef struct packed {
		status_t     status;
		logic [2:0]  object_type;
		logic [31:0] object_size;
		logic [31:0] data_offset;
		logic [31:0] byte_total;
	} result_t;

endpackage

[src/pack_object_header_parser_unit.sv]
// A status item reaches the result ports after the character or end of stream
// that causes it has passed the item queue and then the result queue.
// One item per cycle while no queue is full; the parser updates once per byte.
// Two-entry queues sit between front and back and at the result side.
// Reset: arst_n clears all parser state at once, expected_length returns to
// 340027; each end of stream rearms the parser and keeps expected_length.
// ----------------------------------------------------------------------------
// pack_object_header_parser_unit
// Top level: front classifier, item queue, header parser and result queue.
// ----------------------------------------------------------------------------
module pack_object_header_parser_unit
	import pohp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [7:0]  symbol,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [2:0]  object_type,
	output logic [31:0] object_size,
	output logic [31:0] data_offset,
	output logic [31:0] byte_total,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic    tok_wr;
	token_t  tok_wr_item;
	logic    tok_full;
	logic    tok_rd;
	token_t  tok_rd_item;
	logic    tok_empty;
	logic    res_wr;
	result_t res_wr_item;
	logic    res_full;
	result_t res_rd_item;

	assign cfg_ready = 1'b1;

	pohp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.kind     (kind),
		.symbol   (symbol),
		.tok_full (tok_full),
		.tok_wr   (tok_wr),
		.tok_item (tok_wr_item)
	);

	pohp_tok_q u_tok_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tok_wr),
		.wr_item (tok_wr_item),
		.full    (tok_full),
		.rd_en   (tok_rd),
		.rd_item (tok_rd_item),
		.empty   (tok_empty)
	);

	pohp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.tok_empty (tok_empty),
		.tok_item  (tok_rd_item),
		.tok_rd    (tok_rd),
		.res_full  (res_full),
		.res_wr    (res_wr),
		.res_item  (res_wr_item)
	);

	pohp_res_q u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_wr),
		.wr_item (res_wr_item),
		.full    (res_full),
		.rd_en   (pop),
		.rd_item (res_rd_item),
		.empty   (empty)
	);

	// Drive the result ports from the oldest queued item
	assign status      = res_rd_item.status;
	assign object_type = res_rd_item.object_type;
	assign object_size = res_rd_item.object_size;
	assign data_offset = res_rd_item.data_offset;
	assign byte_total  = res_rd_item.byte_total;

endmodule

[src/pohp_front.sv]
// ----------------------------------------------------------------------------
// pohp_front
// Accepts text characters, pairs hex digits into bytes and classifies items.
// ----------------------------------------------------------------------------
module pohp_front
	import pohp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	output logic   full,
	input  logic   kind,
	input  logic   [7:0] symbol,
	input  logic   tok_full,
	output logic   tok_wr,
	output token_t tok_item
);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;

	logic       half_q, half_d;
	logic [3:0] nib_q, nib_d;
	logic       err_q, err_d;
	logic       take;
	logic       is_ws;
	logic       is_hex;
	logic [3:0] hex_val;

	// Decode one hex digit
	always_comb begin
		is_hex  = 1'b1;
		hex_val = 4'd0;
		if (symbol >= 8'h30 && symbol <= 8'h39) begin
			hex_val = symbol[3:0];
		end else if ((symbol >= 8'h41 && symbol <= 8'h46) ||
		             (symbol >= 8'h61 && symbol <= 8'h66)) begin
			hex_val = symbol[3:0] + 4'd9;
		end else begin
			is_hex = 1'b0;
		end
	end

	assign is_ws = (symbol == CH_SPACE) || (symbol == CH_LF) || (symbol == CH_CR);
	assign full  = tok_full;
	assign take  = push && !tok_full;

	// Classify the item and update pairing state
	always_comb begin
		half_d   = half_q;
		nib_d    = nib_q;
		err_d    = err_q;
		tok_wr   = 1'b0;
		tok_item = '{kind: TK_BYTE, data: {nib_q, hex_val}, pending: half_q};
		if (take) begin
			if (kind) begin
				tok_wr        = 1'b1;
				tok_item.kind = TK_EOS;
				half_d        = 1'b0;
				nib_d         = 4'd0;
				err_d         = 1'b0;
			end else if (!err_q) begin
				if (is_ws) begin
					if (half_q) begin
						tok_wr        = 1'b1;
						tok_item.kind = TK_BADHEX;
						err_d         = 1'b1;
					end
				end else if (!is_hex) begin
					tok_wr        = 1'b1;
					tok_item.kind = TK_BADHEX;
					err_d         = 1'b1;
				end else if (!half_q) begin
					nib_d  = hex_val;
					half_d = 1'b1;
				end else begin
					tok_wr = 1'b1;
					half_d = 1'b0;
				end
			end
		end
	end

	// Hold pairing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= 1'b0;
			nib_q  <= 4'd0;
			err_q  <= 1'b0;
		end else begin
			half_q <= half_d;
			nib_q  <= nib_d;
			err_q  <= err_d;
		end
	end

endmodule

[src/pohp_tok_q.sv]
// ----------------------------------------------------------------------------
// pohp_tok_q
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module pohp_tok_q
	import pohp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  token_t wr_item,
	output logic   full,
	input  logic   rd_en,
	output token_t rd_item,
	output logic   empty
);

	token_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 do_wr;
	logic                 do_rd;

	assign full    = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_item = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	// Store items
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[src/pohp_res_q.sv]
// ----------------------------------------------------------------------------
// pohp_res_q
// Output queue of status items; parts the back from the result consumer.
// ----------------------------------------------------------------------------
module pohp_res_q
	import pohp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  result_t wr_item,
	output logic    full,
	input  logic    rd_en,
	output result_t rd_item,
	output logic    empty
);

	result_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 do_wr;
	logic                 do_rd;

	assign full    = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_item = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	// Store items
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[src/pohp_back.sv]
// ----------------------------------------------------------------------------
// pohp_back
// Parses the pack header and first object header from decoded bytes.
// ----------------------------------------------------------------------------
`include "pack_object_header_parser_unit_defines.svh"

module pohp_back
	import pohp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr,
	input  logic [31:0] cfg_data,
	input  logic        tok_empty,
	input  token_t      tok_item,
	output logic        tok_rd,
	input  logic        res_full,
	output logic        res_wr,
	output result_t     res_item
);

	typedef enum logic [2:0] {
		PH_TYPE,
		PH_SIZE,
		PH_OFS,
		PH_BASE,
		PH_DONE
	} phase_t;

	logic [31:0]       exp_len_q;
	logic [31:0]       cnt_q, cnt_d;
	logic              magic_q, magic_d;
	phase_t            phase_q, phase_d;
	logic [2:0]        type_q, type_d;
	logic [31:0]       size_q, size_d;
	logic [5:0]        shift_q, shift_d;
	logic [OFS_W-1:0]  ofs_q, ofs_d;
	logic [BASE_W-1:0] base_q, base_d;
	logic [31:0]       zlib_q, zlib_d;
	logic              err_q, err_d;
	logic              take;
	logic              byte_err;
	status_t           byte_st;
	logic [7:0]        b;

	function automatic phase_t phase_after_size(input logic [2:0] t);
		if (t == OBJ_OFS_DELTA) begin
			return PH_OFS;
		end else if (t == OBJ_REF_DELTA) begin
			return PH_BASE;
		end
		return PH_DONE;
	endfunction

	assign take = !tok_empty && !res_full;
	assign b    = tok_item.data;

	// Work out next state and any status item
	always_comb begin
		cnt_d    = cnt_q;
		magic_d  = magic_q;
		phase_d  = phase_q;
		type_d   = type_q;
		size_d   = size_q;
		shift_d  = shift_q;
		ofs_d    = ofs_q;
		base_d   = base_q;
		zlib_d   = zlib_q;
		err_d    = err_q;
		byte_err = 1'b0;
		byte_st  = ST_PASS;
		tok_rd   = take;
		res_wr   = 1'b0;
		res_item = '{status: ST_PASS, object_type: type_q, object_size: size_q,
		             data_offset: zlib_q, byte_total: cnt_q};
		if (take) begin
			case (tok_item.kind)
				TK_EOS: begin
					if (!err_q) begin
						res_wr = 1'b1;
						if (tok_item.pending) begin
							res_item.status = ST_BAD_HEX;
						end else if (cnt_q == exp_len_q && magic_q && phase_q == PH_DONE) begin
							res_item.status = ST_PASS;
						end else begin
							res_item.status = ST_HDR_FAIL;
						end
					end
					// rearm for the next stream
					cnt_d   = '0;
					magic_d = 1'b1;
					phase_d = PH_TYPE;
					type_d  = '0;
					size_d  = '0;
					shift_d = 6'(SIZE_SHIFT_INIT);
					ofs_d   = '0;
					base_d  = '0;
					zlib_d  = '0;
					err_d   = 1'b0;
				end
				TK_BADHEX: begin
					if (!err_q) begin
						res_wr          = 1'b1;
						res_item.status = ST_BAD_HEX;
						err_d           = 1'b1;
					end
				end
				TK_BYTE: begin
					if (!err_q) begin
						if (cnt_q < 32'(HEADER_BYTES)) begin
							if (cnt_q < 32'(MAGIC_BYTES) && b != MAGIC[cnt_q[1:0]]) begin
								magic_d = 1'b0;
							end
						end else begin
							case (phase_q)
								PH_TYPE: begin
									type_d  = b[6:4];
									size_d  = {28'd0, b[3:0]};
									phase_d = b[7] ? PH_SIZE : phase_after_size(b[6:4]);
								end
								PH_SIZE: begin
									if (shift_q > 6'(SIZE_SHIFT_MAX)) begin
										byte_err = 1'b1;
										byte_st  = ST_SIZE_OVF;
									end else begin
										size_d  = size_q | ({25'd0, b[6:0]} << shift_q);
										shift_d = shift_q + 6'(SIZE_SHIFT_STEP);
										if (!b[7]) begin
											phase_d = phase_after_size(type_q);
										end
									end
								end
								PH_OFS: begin
									if (ofs_q >= OFS_W'(MAX_OFFSET_BYTES)) begin
										byte_err = 1'b1;
										byte_st  = ST_OFS_OVF;
									end else begin
										ofs_d = ofs_q + 1'b1;
										if (!b[7]) begin
											phase_d = PH_DONE;
										end
									end
								end
								PH_BASE: begin
									if (base_q == BASE_W'(BASE_ID_BYTES - 1)) begin
										phase_d = PH_DONE;
									end else begin
										base_d = base_q + 1'b1;
									end
								end
								default: ;
							endcase
						end
						if (byte_err) begin
							err_d           = 1'b1;
							res_wr          = 1'b1;
							res_item.status = byte_st;
						end else begin
							if (cnt_q != 32'hffff_ffff) begin
								cnt_d = cnt_q + 32'd1;
							end
							if (phase_d == PH_DONE && zlib_q == '0) begin
								zlib_d = cnt_d;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Hold parser state and the length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= EXPECTED_LENGTH_RST;
			cnt_q     <= '0;
			magic_q   <= 1'b1;
			phase_q   <= PH_TYPE;
			type_q    <= '0;
			size_q    <= '0;
			shift_q   <= 6'(SIZE_SHIFT_INIT);
			ofs_q     <= '0;
			base_q    <= '0;
			zlib_q    <= '0;
			err_q     <= 1'b0;
		end else begin
			if (cfg_wr) begin
				exp_len_q <= cfg_data;
			end
			cnt_q   <= cnt_d;
			magic_q <= magic_d;
			phase_q <= phase_d;
			type_q  <= type_d;
			size_q  <= size_d;
			shift_q <= shift_d;
			ofs_q   <= ofs_d;
			base_q  <= base_d;
			zlib_q  <= zlib_d;
			err_q   <= err_d;
		end
	end

	`POHP_ASSERT_NOW(a_no_write_when_full, clk, arst_n, res_wr, !res_full && take, "status item written into a full queue")
	`POHP_ASSERT_NOW(a_quiet_after_error, clk, arst_n, take && err_q && tok_item.kind != TK_EOS, !res_wr, "item given after an error")
	`POHP_ASSERT_NEXT(a_rearm_on_eos, clk, arst_n, take && tok_item.kind == TK_EOS, cnt_q == '0 && !err_q && phase_q == PH_TYPE, "end of stream did not rearm")
	`POHP_ASSERT_NOW(a_offset_only_when_done, clk, arst_n, zlib_q != '0, phase_q == PH_DONE, "data offset set before header end")

endmodule
